[design/reentrant_lock_fifo_waiters_defines.svh]
// Assertion macros for the reentrant lock with a first-in first-out wait queue.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef REENTRANT_LOCK_FIFO_WAITERS_DEFINES_SVH
`define REENTRANT_LOCK_FIFO_WAITERS_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge outside reset.
`define RLFW_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("%m: check failed");

// Same-cycle implication outside reset.
`define RLFW_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: implication failed");

// Next-cycle implication outside reset.
`define RLFW_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication failed");

`else

`define RLFW_ASSERT(lbl, clk, rstn, prop)
`define RLFW_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define RLFW_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[design/rlfw_pkg.sv]
// Shared types and constants for the reentrant lock with a FIFO wait queue.
// Used by rlfw_queue, rlfw_lock and the top level; depends on nothing else.
`default_nettype none

package rlfw_pkg;

    localparam int TID_W    = 4;
    localparam int STATUS_W = 4;
    localparam int DEPTH_W  = 8;

    // Request codes carried on req_type.
    localparam logic REQ_ACQUIRE = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED    = 4'd0,
        ST_REENTERED  = 4'd1,
        ST_QUEUED     = 4'd2,
        ST_NEST_DEC   = 4'd3,
        ST_FREED      = 4'd4,
        ST_HANDOFF    = 4'd5,
        ST_NOT_HOLDER = 4'd6,
        ST_QUEUE_FULL = 4'd7,
        ST_BUSY_ERR   = 4'd8
    } status_t;

    // Commands from the lock logic to the wait queue.
    typedef struct packed {
        logic             push;
        logic             pop;
        logic [TID_W-1:0] push_tid;
    } q_cmd_t;

    // Status of the wait queue seen by the lock logic.
    typedef struct packed {
        logic             empty;
        logic             full;
        logic [TID_W-1:0] head_tid;
    } q_stat_t;

    // One result item.
    typedef struct packed {
        status_t            status;
        logic               woken_valid;
        logic [TID_W-1:0]   woken_thread;
        logic [DEPTH_W-1:0] nest_depth;
    } res_t;

endpackage

`default_nettype wire

[design/rlfw_queue.sv]
// Wait queue: a synchronous memory of thread ids with head, tail and fill count.
// Depends on rlfw_pkg and the assertion macros header.
`default_nettype none
`include "reentrant_lock_fifo_waiters_defines.svh"

module rlfw_queue
    import rlfw_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire q_cmd_t  cmd,
    output q_stat_t      stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

    logic [TID_W-1:0] mem [QUEUE_DEPTH];

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [TID_W-1:0] rd_data_reg;
    logic             fwd_reg;
    logic [TID_W-1:0] fwd_data_reg;
    logic             fwd_hit;

    // Pointer and fill count updates; push and pop never come together.
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        if (cmd.push)
        begin
            tail_next = (tail_reg == LAST_SLOT) ? '0 : tail_reg + 1'b1;
            fill_next = fill_reg + 1'b1;
        end
        if (cmd.pop)
        begin
            head_next = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
            fwd_reg  <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
            fwd_reg  <= fwd_hit;
        end
    end

    // A push into the slot that becomes the head must bypass the memory read.
    assign fwd_hit = cmd.push && (tail_reg == head_next);

    // Memory write port at the tail.
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[tail_reg] <= cmd.push_tid;
        end
    end

    // Memory read port prefetches the next head entry every cycle.
    always_ff @(posedge clk)
    begin
        rd_data_reg  <= mem[head_next];
        fwd_data_reg <= cmd.push_tid;
    end

    // Status towards the lock logic.
    assign stat.empty    = (fill_reg == '0);
    assign stat.full     = (fill_reg == FULL_CNT);
    assign stat.head_tid = fwd_reg ? fwd_data_reg : rd_data_reg;

    `RLFW_ASSERT(a_fill_bound, clk, rst_n, fill_reg <= FULL_CNT)
    `RLFW_ASSERT_IMPL(a_no_push_full, clk, rst_n, cmd.push, fill_reg != FULL_CNT)
    `RLFW_ASSERT_IMPL(a_no_pop_empty, clk, rst_n, cmd.pop, fill_reg != '0)
    `RLFW_ASSERT(a_no_push_pop, clk, rst_n, !(cmd.push && cmd.pop))

endmodule

`default_nettype wire

[design/rlfw_lock.sv]
// Lock holder state, nesting count and waiting mask, with the request decision.
// Depends on rlfw_pkg and the assertion macros header; drives rlfw_queue.
`default_nettype none
`include "reentrant_lock_fifo_waiters_defines.svh"

module rlfw_lock
    import rlfw_pkg::*;
#(
    parameter int NUM_THREADS = 16,
    parameter int MAX_NEST    = 255
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             fire,
    input  wire logic             req_type,
    input  wire logic [TID_W-1:0] thread_id,
    input  wire q_stat_t          q_stat,
    output q_cmd_t                q_cmd,
    output res_t                  res
);

    localparam int ID_SPACE = 2 ** TID_W;
    localparam int MASK_N   = (NUM_THREADS < ID_SPACE) ? NUM_THREADS : ID_SPACE;
    localparam int MIDX_W   = (MASK_N > 1) ? $clog2(MASK_N) : 1;
    localparam int NEST_W   = $clog2(MAX_NEST + 1);
    localparam logic [NEST_W-1:0] NEST_MAX = NEST_W'(MAX_NEST);
    localparam logic [NEST_W-1:0] NEST_ONE = NEST_W'(1);
    localparam bit ALL_IDS = (NUM_THREADS >= ID_SPACE);

    logic              held_reg,  held_next;
    logic [TID_W-1:0]  owner_reg, owner_next;
    logic [NEST_W-1:0] nest_reg,  nest_next;
    logic [MASK_N-1:0] mask_reg,  mask_next;

    logic              tid_ok;
    logic [MIDX_W-1:0] tid_idx;
    logic [MIDX_W-1:0] head_idx;
    status_t           status;
    logic [NEST_W-1:0] depth_now;

    assign tid_ok   = ALL_IDS || (32'(thread_id) < 32'(NUM_THREADS));
    assign tid_idx  = thread_id[MIDX_W-1:0];
    assign head_idx = q_stat.head_tid[MIDX_W-1:0];

    // Request decision and next state of the lock.
    always_comb
    begin
        held_next    = held_reg;
        owner_next   = owner_reg;
        nest_next    = nest_reg;
        mask_next    = mask_reg;
        q_cmd.push   = 1'b0;
        q_cmd.pop    = 1'b0;
        q_cmd.push_tid = thread_id;
        status       = ST_NOT_HOLDER;
        if (!tid_ok)
        begin
            status = ST_NOT_HOLDER;
        end
        else if (req_type == REQ_ACQUIRE)
        begin
            if (!held_reg)
            begin
                status     = ST_GRANTED;
                held_next  = 1'b1;
                owner_next = thread_id;
                nest_next  = NEST_ONE;
            end
            else if (owner_reg == thread_id)
            begin
                if (nest_reg >= NEST_MAX)
                begin
                    status = ST_BUSY_ERR;
                end
                else
                begin
                    status    = ST_REENTERED;
                    nest_next = nest_reg + 1'b1;
                end
            end
            else if (mask_reg[tid_idx])
            begin
                status = ST_BUSY_ERR;
            end
            else if (q_stat.full)
            begin
                status = ST_QUEUE_FULL;
            end
            else
            begin
                status             = ST_QUEUED;
                q_cmd.push         = fire;
                mask_next[tid_idx] = 1'b1;
            end
        end
        else
        begin
            if (!held_reg || (owner_reg != thread_id))
            begin
                status = ST_NOT_HOLDER;
            end
            else if (nest_reg > NEST_ONE)
            begin
                status    = ST_NEST_DEC;
                nest_next = nest_reg - 1'b1;
            end
            else if (!q_stat.empty)
            begin
                status              = ST_HANDOFF;
                q_cmd.pop           = fire;
                owner_next          = q_stat.head_tid;
                nest_next           = NEST_ONE;
                mask_next[head_idx] = 1'b0;
            end
            else
            begin
                status     = ST_FREED;
                held_next  = 1'b0;
                owner_next = '0;
                nest_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= 1'b0;
            owner_reg <= '0;
            nest_reg  <= '0;
            mask_reg  <= '0;
        end
        else if (fire)
        begin
            held_reg  <= held_next;
            owner_reg <= owner_next;
            nest_reg  <= nest_next;
            mask_reg  <= mask_next;
        end
    end

    // Result fields; the depth is the count after the request, zero when free.
    assign depth_now        = held_next ? nest_next : '0;
    assign res.status       = status;
    assign res.woken_valid  = (status == ST_HANDOFF);
    assign res.woken_thread = (status == ST_HANDOFF) ? q_stat.head_tid : '0;

    generate
        if (NEST_W >= DEPTH_W)
        begin : g_depth_cut
            assign res.nest_depth = depth_now[DEPTH_W-1:0];
        end
        else
        begin : g_depth_ext
            assign res.nest_depth = {{(DEPTH_W - NEST_W){1'b0}}, depth_now};
        end
    endgenerate

    `RLFW_ASSERT_IMPL(a_held_nest, clk, rst_n, held_reg, nest_reg != '0)
    `RLFW_ASSERT_IMPL(a_free_clean, clk, rst_n, !held_reg, nest_reg == '0 && owner_reg == '0)
    `RLFW_ASSERT_IMPL(a_free_no_waiters, clk, rst_n, !held_reg, mask_reg == '0)
    `RLFW_ASSERT_IMPL(a_mask_queue, clk, rst_n, q_stat.empty, mask_reg == '0)

endmodule

`default_nettype wire

[design/reentrant_lock_fifo_waiters.sv]
// Top level of the reentrant lock with a FIFO wait queue: handshakes and result register.
// Depends on rlfw_pkg, rlfw_lock and rlfw_queue.
//
//   Channel  Handshake              Payload
//   -------  ---------------------  ----------------------------------------------
//   in       in_valid / in_stall    req_type, thread_id
//   out      out_valid / out_stall  status, woken_valid, woken_thread, nest_depth
//
// The lock state updates in place and the queue memory always holds its head
// entry prefetched in a read register, so one request is taken per cycle while
// in_stall is low, and its result appears in the output register the cycle
// after the transfer. Reset clears the lock and queue pointers at once, with no
// clearing pass. in_stall rises only while a result is held and out_stall is
// high.
`default_nettype none

module reentrant_lock_fifo_waiters
    import rlfw_pkg::*;
#(
    parameter int NUM_THREADS = 16,
    parameter int QUEUE_DEPTH = 16,
    parameter int MAX_NEST    = 255
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               req_type,
    input  wire logic [TID_W-1:0]   thread_id,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [STATUS_W-1:0]     status,
    output logic                    woken_valid,
    output logic [TID_W-1:0]        woken_thread,
    output logic [DEPTH_W-1:0]      nest_depth
);

    logic    fire;
    logic    out_valid_reg, out_valid_next;
    res_t    res;
    res_t    res_reg;
    q_cmd_t  q_cmd;
    q_stat_t q_stat;

    // Input transfer is blocked only while a result waits on a stalled output.
    assign in_stall = out_valid_reg && out_stall;
    assign fire     = in_valid && !in_stall;

    rlfw_lock #(
        .NUM_THREADS (NUM_THREADS),
        .MAX_NEST    (MAX_NEST)
    ) u_lock (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .req_type  (req_type),
        .thread_id (thread_id),
        .q_stat    (q_stat),
        .q_cmd     (q_cmd),
        .res       (res)
    );

    rlfw_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (q_cmd),
        .stat  (q_stat)
    );

    // Output valid: set by an input transfer, cleared once the result is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = res_reg.status;
    assign woken_valid  = res_reg.woken_valid;
    assign woken_thread = res_reg.woken_thread;
    assign nest_depth   = res_reg.nest_depth;

endmodule

`default_nettype wire
